[rtl/csm_pkg.sv]
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types, codes and helpers for the charger session state machine.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int DATA_W  = 16;
    localparam int TIMER_W = 17;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // session states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_HANDSHAKE = 3'd1;
    localparam logic [2:0] ST_READY     = 3'd2;
    localparam logic [2:0] ST_CHARGING  = 3'd3;
    localparam logic [2:0] ST_STOP      = 3'd4;
    localparam logic [2:0] ST_FAULT     = 3'd5;

    // item opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;

    // command bytes
    localparam logic [7:0] CMD_HANDSHAKE = 8'h01;
    localparam logic [7:0] CMD_READY     = 8'h02;
    localparam logic [7:0] CMD_START     = 8'h03;
    localparam logic [7:0] CMD_STOP      = 8'h04;
    localparam logic [7:0] CMD_FAULT     = 8'hFF;

    // reported status codes
    localparam logic [7:0] STATUS_IDLE      = 8'h00;
    localparam logic [7:0] STATUS_HANDSHAKE = 8'h01;
    localparam logic [7:0] STATUS_READY     = 8'h02;
    localparam logic [7:0] STATUS_CHARGING  = 8'h03;
    localparam logic [7:0] STATUS_STOP      = 8'h04;
    localparam logic [7:0] STATUS_FAULT     = 8'hFF;

    // minimum frame lengths
    localparam logic [3:0] MIN_COMMAND_LEN = 4'd1;
    localparam logic [3:0] MIN_REQUEST_LEN = 4'd4;

    // register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_MAX_VOLTAGE       = 2'd0;
    localparam logic [1:0] REG_MAX_CURRENT       = 2'd1;
    localparam logic [1:0] REG_HANDSHAKE_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_CHARGING_TIMEOUT  = 2'd3;

    localparam logic [DATA_W-1:0] RST_MAX_VOLTAGE       = 16'd500;
    localparam logic [DATA_W-1:0] RST_MAX_CURRENT       = 16'd125;
    localparam logic [DATA_W-1:0] RST_HANDSHAKE_TIMEOUT = 16'd5000;
    localparam logic [DATA_W-1:0] RST_CHARGING_TIMEOUT  = 16'd60000;

    typedef struct packed {
        logic [DATA_W-1:0] volt_cap;
        logic [DATA_W-1:0] amp_cap;
        logic [DATA_W-1:0] hs_timeout;
        logic [DATA_W-1:0] chg_timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [DATA_W-1:0] tick_ms;
        logic              car_ready;
        logic [3:0]        frame_length;
        logic [7:0]        command;
        logic [DATA_W-1:0] volt_req;
        logic [DATA_W-1:0] amp_req;
    } item_t;

    // timer add, saturating at the all-ones value
    function automatic logic [TIMER_W-1:0] sat_add(
        input logic [TIMER_W-1:0] t,
        input logic [DATA_W-1:0]  d
    );
        logic [TIMER_W:0] sum;
        begin
            sum = {1'b0, t} + {{(TIMER_W+1-DATA_W){1'b0}}, d};
            sat_add = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
        end
    endfunction

endpackage

[rtl/csm_if.sv]
// ----------------------------------------------------------------------------
// csm_if
// Valid/ready channels for session items and session results.
// ----------------------------------------------------------------------------
interface csm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] tick_ms;
    logic        car_ready;
    logic [3:0]  frame_length;
    logic [7:0]  command;
    logic [15:0] volt_req;
    logic [15:0] amp_req;

    modport source (
        output valid, opcode, tick_ms, car_ready, frame_length, command,
               volt_req, amp_req,
        input  ready
    );
    modport sink (
        input  valid, opcode, tick_ms, car_ready, frame_length, command,
               volt_req, amp_req,
        output ready
    );
endinterface

interface csm_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  status_code;
    logic        fault_flag;
    logic        twelve_volt_on;
    logic        contactor_on;
    logic [15:0] report_voltage;
    logic [15:0] report_current;

    modport source (
        output valid, status_code, fault_flag, twelve_volt_on, contactor_on,
               report_voltage, report_current,
        input  ready
    );
    modport sink (
        input  valid, status_code, fault_flag, twelve_volt_on, contactor_on,
               report_voltage, report_current,
        output ready
    );
endinterface

[rtl/charger_session_state_machine.sv]
// ----------------------------------------------------------------------------
// charger_session_state_machine
// Charger side of a DC charging session: tick, command and request items
// in, one status result out per item.
// ----------------------------------------------------------------------------
// Each request on in_ch produces exactly one result on out_ch, in order. The
// block takes one request per clock cycle; a request passes an input register
// and the combinational session update into the result register that offers
// its result on out_ch. The only stall comes from out_ch:
// while a result waits, one more request is still accepted into the input
// register. Configuration registers are APB mapped at 0x0 (max voltage),
// 0x4 (max current), 0x8 (handshake timeout, ms) and 0xC (charging timeout,
// ms), 16 bits each; write them only while no request is in flight.
module charger_session_state_machine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    csm_item_if.sink                    in_ch,
    csm_result_if.source                out_ch
);

    csm_pkg::cfg_t  cfg;
    csm_pkg::item_t item;
    logic           item_valid;
    logic           take;

    csm_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    csm_session u_session (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_ch     (out_ch)
    );

endmodule

[rtl/csm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// csm_cfg_regs
// APB register file holding the voltage/current clamps and the timeouts.
// ----------------------------------------------------------------------------
module csm_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output csm_pkg::cfg_t                 cfg
);

    csm_pkg::cfg_t cfg_reg;
    csm_pkg::cfg_t cfg_next;
    logic [1:0]    reg_index;
    logic          wr_en;
    logic [15:0]   rd_value;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                csm_pkg::REG_MAX_VOLTAGE:       cfg_next.volt_cap = pwdata[15:0];
                csm_pkg::REG_MAX_CURRENT:       cfg_next.amp_cap = pwdata[15:0];
                csm_pkg::REG_HANDSHAKE_TIMEOUT: cfg_next.hs_timeout = pwdata[15:0];
                csm_pkg::REG_CHARGING_TIMEOUT:  cfg_next.chg_timeout = pwdata[15:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            csm_pkg::REG_MAX_VOLTAGE:       rd_value = cfg_reg.volt_cap;
            csm_pkg::REG_MAX_CURRENT:       rd_value = cfg_reg.amp_cap;
            csm_pkg::REG_HANDSHAKE_TIMEOUT: rd_value = cfg_reg.hs_timeout;
            csm_pkg::REG_CHARGING_TIMEOUT:  rd_value = cfg_reg.chg_timeout;
            default:                        rd_value = '0;
        endcase
    end

    assign prdata = {16'd0, rd_value};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volt_cap    <= csm_pkg::RST_MAX_VOLTAGE;
            cfg_reg.amp_cap     <= csm_pkg::RST_MAX_CURRENT;
            cfg_reg.hs_timeout  <= csm_pkg::RST_HANDSHAKE_TIMEOUT;
            cfg_reg.chg_timeout <= csm_pkg::RST_CHARGING_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/csm_in_stage.sv]
// ----------------------------------------------------------------------------
// csm_in_stage
// Input register: captures one request and holds it until the session
// logic takes it.
// ----------------------------------------------------------------------------
module csm_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    csm_item_if.sink       in_ch,
    input  logic           take,
    output logic           item_valid,
    output csm_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    csm_pkg::item_t item_reg;
    logic           accept;

    // a held request leaves in the same cycle a new one arrives
    assign in_ch.ready = !valid_reg || take;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode       <= in_ch.opcode;
            item_reg.tick_ms      <= in_ch.tick_ms;
            item_reg.car_ready    <= in_ch.car_ready;
            item_reg.frame_length <= in_ch.frame_length;
            item_reg.command      <= in_ch.command;
            item_reg.volt_req     <= in_ch.volt_req;
            item_reg.amp_req      <= in_ch.amp_req;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/csm_session.sv]
// ----------------------------------------------------------------------------
// csm_session
// Session state, timers and output levels, updated once per request, with
// the result register toward the output channel.
// ----------------------------------------------------------------------------
module csm_session (
    input  logic           clk,
    input  logic           rst_n,
    input  csm_pkg::cfg_t  cfg,
    input  logic           item_valid,
    input  csm_pkg::item_t item,
    output logic           take,
    csm_result_if.source   out_ch
);

    logic [2:0]                       state_reg, state_next;
    logic [csm_pkg::TIMER_W-1:0]      hs_elapsed_reg, hs_elapsed_next;
    logic [csm_pkg::TIMER_W-1:0]      ch_elapsed_reg, ch_elapsed_next;
    logic                             supply_reg, supply_next;
    logic                             contactor_reg, contactor_next;
    logic [csm_pkg::DATA_W-1:0]       held_voltage_reg, held_voltage_next;
    logic [csm_pkg::DATA_W-1:0]       held_current_reg, held_current_next;

    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       status_reg, status_next;
    logic                             fault_reg;
    logic                             twelve_reg;
    logic                             cont_out_reg;
    logic [csm_pkg::DATA_W-1:0]       rep_voltage_reg, rep_voltage_next;
    logic [csm_pkg::DATA_W-1:0]       rep_current_reg, rep_current_next;

    logic                             advance;
    logic                             fire;
    logic                             report;

    assign advance = !out_valid_reg || out_ch.ready;
    assign fire    = item_valid && advance;
    assign take    = advance;

    always_comb
    begin
        state_next        = state_reg;
        hs_elapsed_next   = hs_elapsed_reg;
        ch_elapsed_next   = ch_elapsed_reg;
        supply_next       = supply_reg;
        contactor_next    = contactor_reg;
        held_voltage_next = held_voltage_reg;
        held_current_next = held_current_reg;

        case (item.opcode)
            csm_pkg::OP_TICK:
            begin
                case (state_reg)
                    csm_pkg::ST_IDLE:
                    begin
                        supply_next    = 1'b0;
                        contactor_next = 1'b0;
                    end
                    csm_pkg::ST_HANDSHAKE:
                    begin
                        supply_next     = 1'b1;
                        hs_elapsed_next = csm_pkg::sat_add(hs_elapsed_reg, item.tick_ms);
                        if (hs_elapsed_next > {1'b0, cfg.hs_timeout})
                            state_next = csm_pkg::ST_FAULT;
                    end
                    csm_pkg::ST_READY:
                    begin
                        if (!item.car_ready)
                            state_next = csm_pkg::ST_FAULT;
                    end
                    csm_pkg::ST_CHARGING:
                    begin
                        contactor_next  = 1'b1;
                        ch_elapsed_next = csm_pkg::sat_add(ch_elapsed_reg, item.tick_ms);
                        if (!item.car_ready ||
                            ch_elapsed_next > {1'b0, cfg.chg_timeout})
                            state_next = csm_pkg::ST_STOP;
                    end
                    csm_pkg::ST_STOP:
                    begin
                        contactor_next = 1'b0;
                        state_next     = csm_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next     = csm_pkg::ST_FAULT;
                        supply_next    = 1'b0;
                        contactor_next = 1'b0;
                    end
                endcase
            end
            csm_pkg::OP_COMMAND:
            begin
                if (item.frame_length >= csm_pkg::MIN_COMMAND_LEN)
                begin
                    case (item.command)
                        csm_pkg::CMD_HANDSHAKE:
                        begin
                            if (state_reg == csm_pkg::ST_IDLE)
                            begin
                                state_next      = csm_pkg::ST_HANDSHAKE;
                                hs_elapsed_next = '0;
                            end
                        end
                        csm_pkg::CMD_READY:
                        begin
                            if (state_reg == csm_pkg::ST_HANDSHAKE)
                            begin
                                state_next      = csm_pkg::ST_READY;
                                hs_elapsed_next = '0;
                            end
                        end
                        csm_pkg::CMD_START:
                        begin
                            if (state_reg == csm_pkg::ST_READY)
                            begin
                                state_next      = csm_pkg::ST_CHARGING;
                                ch_elapsed_next = '0;
                            end
                        end
                        csm_pkg::CMD_STOP:
                        begin
                            if (state_reg == csm_pkg::ST_READY ||
                                state_reg == csm_pkg::ST_CHARGING)
                                state_next = csm_pkg::ST_STOP;
                        end
                        csm_pkg::CMD_FAULT:
                        begin
                            state_next = csm_pkg::ST_FAULT;
                        end
                        default:
                        begin
                            state_next = state_reg;
                        end
                    endcase
                end
            end
            csm_pkg::OP_REQUEST:
            begin
                if (item.frame_length >= csm_pkg::MIN_REQUEST_LEN)
                begin
                    held_voltage_next = (item.volt_req <= cfg.volt_cap) ?
                                        item.volt_req : cfg.volt_cap;
                    held_current_next = (item.amp_req <= cfg.amp_cap) ?
                                        item.amp_req : cfg.amp_cap;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_comb
    begin
        case (state_next)
            csm_pkg::ST_IDLE:      status_next = csm_pkg::STATUS_IDLE;
            csm_pkg::ST_HANDSHAKE: status_next = csm_pkg::STATUS_HANDSHAKE;
            csm_pkg::ST_READY:     status_next = csm_pkg::STATUS_READY;
            csm_pkg::ST_CHARGING:  status_next = csm_pkg::STATUS_CHARGING;
            csm_pkg::ST_STOP:      status_next = csm_pkg::STATUS_STOP;
            default:               status_next = csm_pkg::STATUS_FAULT;
        endcase
    end

    assign report           = (state_next == csm_pkg::ST_READY) ||
                              (state_next == csm_pkg::ST_CHARGING);
    assign rep_voltage_next = report ? held_voltage_next : '0;
    assign rep_current_next = report ? held_current_next : '0;

    always_comb
    begin
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= csm_pkg::ST_IDLE;
            hs_elapsed_reg   <= '0;
            ch_elapsed_reg   <= '0;
            supply_reg       <= 1'b0;
            contactor_reg    <= 1'b0;
            held_voltage_reg <= '0;
            held_current_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg        <= state_next;
                hs_elapsed_reg   <= hs_elapsed_next;
                ch_elapsed_reg   <= ch_elapsed_next;
                supply_reg       <= supply_next;
                contactor_reg    <= contactor_next;
                held_voltage_reg <= held_voltage_next;
                held_current_reg <= held_current_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg      <= status_next;
            fault_reg       <= (status_next == csm_pkg::STATUS_FAULT);
            twelve_reg      <= supply_next;
            cont_out_reg    <= contactor_next;
            rep_voltage_reg <= rep_voltage_next;
            rep_current_reg <= rep_current_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status_code    = status_reg;
    assign out_ch.fault_flag     = fault_reg;
    assign out_ch.twelve_volt_on = twelve_reg;
    assign out_ch.contactor_on   = cont_out_reg;
    assign out_ch.report_voltage = rep_voltage_reg;
    assign out_ch.report_current = rep_current_reg;

`ifndef SYNTHESIS
    // fault holds until reset
    a_fault_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == csm_pkg::ST_FAULT |=> state_reg == csm_pkg::ST_FAULT)
        else $error("session left fault state");

    // session state moves only when a request is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg) && $stable(hs_elapsed_reg) && $stable(ch_elapsed_reg))
        else $error("session state changed without a request");

    // fault flag agrees with status code
    a_fault_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> fault_reg == (status_reg == csm_pkg::STATUS_FAULT))
        else $error("fault flag disagrees with status code");

    // request values are reported only while ready or charging
    a_report_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != csm_pkg::STATUS_READY &&
        status_reg != csm_pkg::STATUS_CHARGING
        |-> rep_voltage_reg == '0 && rep_current_reg == '0)
        else $error("request reported outside ready or charging");

    // a processed request always leaves a result pending
    a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed request produced no result");
`endif

endmodule

[dv/charger_session_state_machine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// charger_session_state_machine_tb
// Drives tick, command and request frames into the session machine through
// valid/ready channels and checks every status result against a predictor
// that tracks the session state, timers, output levels and held request.
// The register settings change between phases, each with its own idling.
// ----------------------------------------------------------------------------
module charger_session_state_machine_tb;

    localparam int          QUIET_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES = 6;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic [7:0]  CMD_UNLISTED  = 8'h5A;

    typedef struct {
        logic [2:0]                  state;
        logic [csm_pkg::TIMER_W-1:0] hs_ms;
        logic [csm_pkg::TIMER_W-1:0] chg_ms;
        logic                        supply;
        logic                        contactor;
        logic [15:0]                 volt;
        logic [15:0]                 amps;
        csm_pkg::cfg_t               cfg;
    } session_t;

    typedef struct packed {
        logic [7:0]  status_code;
        logic        fault_flag;
        logic        twelve_volt_on;
        logic        contactor_on;
        logic [15:0] report_voltage;
        logic [15:0] report_current;
    } status_t;

    logic                        clk;
    logic                        rst_n    = 1'b0;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [csm_pkg::PADDR_W-1:0] paddr    = '0;
    logic [31:0]                 pwdata   = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    logic                        in_valid  = 1'b0;
    csm_pkg::item_t              cur_item  = '0;
    logic                        res_ready = 1'b0;

    csm_pkg::item_t     pending_items[$];
    status_t            expected_status[$];
    session_t           live;   // follows accepted requests
    session_t           plan;   // runs ahead while the stimulus is built

    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        items_queued   = 0;
    int unsigned        results_seen   = 0;
    int unsigned        mismatches     = 0;
    int unsigned        quiet_cycles   = 0;
    int unsigned        settings       = 1;
    int unsigned        sessions       = 0;
    logic [2:0]         fault_from     = csm_pkg::ST_FAULT;

    csm_item_if   item_ch ();
    csm_result_if result_ch ();

    assign item_ch.valid        = in_valid;
    assign item_ch.opcode       = cur_item.opcode;
    assign item_ch.tick_ms      = cur_item.tick_ms;
    assign item_ch.car_ready    = cur_item.car_ready;
    assign item_ch.frame_length = cur_item.frame_length;
    assign item_ch.command      = cur_item.command;
    assign item_ch.volt_req     = cur_item.volt_req;
    assign item_ch.amp_req      = cur_item.amp_req;
    assign result_ch.ready      = res_ready;

    charger_session_state_machine DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (item_ch),
        .out_ch  (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // session predictor
    // ------------------------------------------------------------------
    function automatic session_t session_reset();
        session_t s;
        s.state           = csm_pkg::ST_IDLE;
        s.hs_ms           = '0;
        s.chg_ms          = '0;
        s.supply          = 1'b0;
        s.contactor       = 1'b0;
        s.volt            = '0;
        s.amps            = '0;
        s.cfg.volt_cap    = csm_pkg::RST_MAX_VOLTAGE;
        s.cfg.amp_cap     = csm_pkg::RST_MAX_CURRENT;
        s.cfg.hs_timeout  = csm_pkg::RST_HANDSHAKE_TIMEOUT;
        s.cfg.chg_timeout = csm_pkg::RST_CHARGING_TIMEOUT;
        return s;
    endfunction

    function automatic logic [csm_pkg::TIMER_W-1:0] timer_add(
        input logic [csm_pkg::TIMER_W-1:0] t,
        input logic [15:0] d
    );
        logic [csm_pkg::TIMER_W:0] sum;
        sum = {1'b0, t} + {2'b00, d};
        return sum[csm_pkg::TIMER_W] ? {csm_pkg::TIMER_W{1'b1}}
                                     : sum[csm_pkg::TIMER_W-1:0];
    endfunction

    function automatic status_t session_step(ref session_t s, input csm_pkg::item_t it);
        status_t r;
        logic    shown;
        case (it.opcode)
            csm_pkg::OP_TICK:
                case (s.state)
                    csm_pkg::ST_IDLE:
                    begin
                        s.supply    = 1'b0;
                        s.contactor = 1'b0;
                    end
                    csm_pkg::ST_HANDSHAKE:
                    begin
                        s.supply = 1'b1;
                        s.hs_ms  = timer_add(s.hs_ms, it.tick_ms);
                        if (s.hs_ms > {1'b0, s.cfg.hs_timeout})
                            s.state = csm_pkg::ST_FAULT;
                    end
                    csm_pkg::ST_READY:
                        if (!it.car_ready)
                            s.state = csm_pkg::ST_FAULT;
                    csm_pkg::ST_CHARGING:
                    begin
                        s.contactor = 1'b1;
                        s.chg_ms    = timer_add(s.chg_ms, it.tick_ms);
                        if (!it.car_ready || s.chg_ms > {1'b0, s.cfg.chg_timeout})
                            s.state = csm_pkg::ST_STOP;
                    end
                    csm_pkg::ST_STOP:
                    begin
                        s.contactor = 1'b0;
                        s.state     = csm_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        s.state     = csm_pkg::ST_FAULT;
                        s.supply    = 1'b0;
                        s.contactor = 1'b0;
                    end
                endcase
            csm_pkg::OP_COMMAND:
                if (it.frame_length >= csm_pkg::MIN_COMMAND_LEN)
                    case (it.command)
                        csm_pkg::CMD_HANDSHAKE:
                            if (s.state == csm_pkg::ST_IDLE)
                            begin
                                s.state = csm_pkg::ST_HANDSHAKE;
                                s.hs_ms = '0;
                            end
                        csm_pkg::CMD_READY:
                            if (s.state == csm_pkg::ST_HANDSHAKE)
                            begin
                                s.state = csm_pkg::ST_READY;
                                s.hs_ms = '0;
                            end
                        csm_pkg::CMD_START:
                            if (s.state == csm_pkg::ST_READY)
                            begin
                                s.state  = csm_pkg::ST_CHARGING;
                                s.chg_ms = '0;
                            end
                        csm_pkg::CMD_STOP:
                            if (s.state == csm_pkg::ST_CHARGING ||
                                s.state == csm_pkg::ST_READY)
                                s.state = csm_pkg::ST_STOP;
                        csm_pkg::CMD_FAULT:
                            s.state = csm_pkg::ST_FAULT;
                        default: ;
                    endcase
            csm_pkg::OP_REQUEST:
                if (it.frame_length >= csm_pkg::MIN_REQUEST_LEN)
                begin
                    s.volt = (it.volt_req <= s.cfg.volt_cap) ? it.volt_req : s.cfg.volt_cap;
                    s.amps = (it.amp_req <= s.cfg.amp_cap) ? it.amp_req : s.cfg.amp_cap;
                end
            default: ;
        endcase

        case (s.state)
            csm_pkg::ST_IDLE:      r.status_code = csm_pkg::STATUS_IDLE;
            csm_pkg::ST_HANDSHAKE: r.status_code = csm_pkg::STATUS_HANDSHAKE;
            csm_pkg::ST_READY:     r.status_code = csm_pkg::STATUS_READY;
            csm_pkg::ST_CHARGING:  r.status_code = csm_pkg::STATUS_CHARGING;
            csm_pkg::ST_STOP:      r.status_code = csm_pkg::STATUS_STOP;
            default:               r.status_code = csm_pkg::STATUS_FAULT;
        endcase
        shown            = (s.state == csm_pkg::ST_READY || s.state == csm_pkg::ST_CHARGING);
        r.fault_flag     = (r.status_code == csm_pkg::STATUS_FAULT);
        r.twelve_volt_on = s.supply;
        r.contactor_on   = s.contactor;
        r.report_voltage = shown ? s.volt : 16'd0;
        r.report_current = shown ? s.amps : 16'd0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic csm_pkg::item_t tick_item(input logic [15:0] ms, input logic car);
        csm_pkg::item_t it;
        it              = '0;
        it.opcode       = csm_pkg::OP_TICK;
        it.tick_ms      = ms;
        it.car_ready    = car;
        it.frame_length = 4'($urandom);
        it.command      = 8'($urandom);
        return it;
    endfunction

    function automatic csm_pkg::item_t cmd_item(input logic [3:0] len, input logic [7:0] cmd);
        csm_pkg::item_t it;
        it              = '0;
        it.opcode       = csm_pkg::OP_COMMAND;
        it.frame_length = len;
        it.command      = cmd;
        it.volt_req     = 16'($urandom);
        return it;
    endfunction

    function automatic csm_pkg::item_t req_item(input logic [3:0] len, input logic [15:0] v,
                                                input logic [15:0] c);
        csm_pkg::item_t it;
        it              = '0;
        it.opcode       = csm_pkg::OP_REQUEST;
        it.frame_length = len;
        it.volt_req     = v;
        it.amp_req      = c;
        it.tick_ms      = 16'($urandom);
        return it;
    endfunction

    // request values around the clamp
    function automatic logic [15:0] near_limit(input logic [15:0] lim);
        case ($urandom_range(3))
            0:       return lim;
            1:       return lim + 16'd1;
            2:       return 16'($urandom_range(lim));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly walks the session forward from the state it is in; a share of
    // items is raw noise with any field value.
    function automatic csm_pkg::item_t pick_item(input session_t s, input bit fault_ok);
        csm_pkg::item_t it;
        int unsigned    roll;
        int unsigned    room;
        roll = $urandom_range(99);
        it   = tick_item(16'($urandom), 1'b1);
        if (roll < 12)
        begin
            it.opcode       = 2'($urandom_range(3));
            it.car_ready    = 1'($urandom);
            it.frame_length = 4'($urandom);
            it.command      = 8'($urandom);
            it.volt_req     = 16'($urandom);
            it.amp_req      = 16'($urandom);
        end
        else if (fault_ok && roll < 22)
        begin
            it = cmd_item(4'($urandom_range(15, 1)), csm_pkg::CMD_FAULT);
        end
        else if (roll < 34)
        begin
            it = req_item(4'($urandom_range(15, 4)), near_limit(s.cfg.volt_cap),
                          near_limit(s.cfg.amp_cap));
        end
        else
        begin
            case (s.state)
                csm_pkg::ST_IDLE:
                    if (roll < 60)
                        it = cmd_item(4'($urandom_range(15, 1)), csm_pkg::CMD_HANDSHAKE);
                csm_pkg::ST_HANDSHAKE:
                begin
                    room = s.cfg.hs_timeout - s.hs_ms;
                    if (roll < 62)
                        it = cmd_item(4'($urandom_range(15, 1)), csm_pkg::CMD_READY);
                    else
                        it = tick_item((roll % 4 == 0) ? 16'(room) : 16'($urandom_range(room / 3)),
                                       1'($urandom));
                end
                csm_pkg::ST_READY:
                    if (roll < 58)
                        it = cmd_item(4'($urandom_range(15, 1)), csm_pkg::CMD_START);
                    else if (roll < 64)
                        it = cmd_item(4'($urandom_range(15, 1)), csm_pkg::CMD_STOP);
                    else
                        it = tick_item(16'($urandom), fault_ok ? 1'($urandom) : 1'b1);
                csm_pkg::ST_CHARGING:
                begin
                    room = s.cfg.chg_timeout - s.chg_ms;
                    if (roll < 40)
                        it = cmd_item(4'($urandom_range(15, 1)), csm_pkg::CMD_STOP);
                    else if (roll < 45)
                        it = tick_item(16'(room + 1), 1'b1);
                    else if (roll < 50)
                        it = tick_item(16'($urandom_range(room)), 1'b0);
                    else
                        it = tick_item(16'($urandom_range(room / 6 + 1)), 1'b1);
                end
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic queue_item(input csm_pkg::item_t it);
        logic [2:0] was;
        was = plan.state;
        void'(session_step(plan, it));
        if (was != csm_pkg::ST_CHARGING && plan.state == csm_pkg::ST_CHARGING)
            sessions++;
        if (was != csm_pkg::ST_FAULT && plan.state == csm_pkg::ST_FAULT)
            fault_from = was;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // fault is terminal, so it is kept out until the last phase
    task automatic queue_random(input int count, input bit fault_ok);
        csm_pkg::item_t it;
        session_t       trial;
        for (int n = 0; n < count; n++)
        begin
            do
            begin
                it    = pick_item(plan, fault_ok);
                trial = plan;
                void'(session_step(trial, it));
            end
            while (!fault_ok && plan.state != csm_pkg::ST_FAULT &&
                   trial.state == csm_pkg::ST_FAULT);
            queue_item(it);
        end
    endtask

    task automatic drain();
        while (results_seen != items_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            csm_pkg::REG_MAX_VOLTAGE:
            begin
                plan.cfg.volt_cap = val;
                live.cfg.volt_cap = val;
            end
            csm_pkg::REG_MAX_CURRENT:
            begin
                plan.cfg.amp_cap = val;
                live.cfg.amp_cap = val;
            end
            csm_pkg::REG_HANDSHAKE_TIMEOUT:
            begin
                plan.cfg.hs_timeout = val;
                live.cfg.hs_timeout = val;
            end
            default:
            begin
                plan.cfg.chg_timeout = val;
                live.cfg.chg_timeout = val;
            end
        endcase
    endtask

    task automatic run_phase(input logic [15:0] vmax, input logic [15:0] imax,
                             input logic [15:0] hs, input logic [15:0] chg,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input int count);
        drain();
        reg_write(csm_pkg::REG_MAX_VOLTAGE, vmax);
        reg_write(csm_pkg::REG_MAX_CURRENT, imax);
        reg_write(csm_pkg::REG_HANDSHAKE_TIMEOUT, hs);
        reg_write(csm_pkg::REG_CHARGING_TIMEOUT, chg);
        settings++;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(count, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // driver, monitor and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && item_ch.ready)
                expected_status.push_back(session_step(live, cur_item));
            if (!in_valid || item_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        status_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && res_ready)
            begin
                results_seen++;
                if (expected_status.size() == 0)
                begin
                    $error("status result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("status_code", want.status_code, result_ch.status_code);
                    check_field("fault_flag", want.fault_flag, result_ch.fault_flag);
                    check_field("twelve_volt_on", want.twelve_volt_on,
                                result_ch.twelve_volt_on);
                    check_field("contactor_on", want.contactor_on, result_ch.contactor_on);
                    check_field("report_voltage", want.report_voltage,
                                result_ch.report_voltage);
                    check_field("report_current", want.report_current,
                                result_ch.report_current);
                end
            end
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && item_ch.ready) || (result_ch.valid && res_ready) ||
            results_seen == items_queued)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("charger_session_state_machine: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        live = session_reset();
        plan = session_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk with reset settings
        queue_item(tick_item(16'd0, 1'b0));
        queue_item(req_item(4'd4, 16'hFFFF, 16'hFFFF));
        queue_item(req_item(4'd3, 16'd1, 16'd1));
        queue_item(cmd_item(4'd0, csm_pkg::CMD_FAULT));
        queue_item(cmd_item(4'd15, csm_pkg::CMD_START));
        queue_item('{opcode: OP_UNUSED, tick_ms: 16'hFFFF, car_ready: 1'b1,
                     frame_length: 4'hF, command: 8'hFF, volt_req: 16'hFFFF,
                     amp_req: 16'hFFFF});
        queue_item(cmd_item(4'd1, csm_pkg::CMD_STOP));
        queue_item(cmd_item(4'd1, csm_pkg::CMD_HANDSHAKE));
        queue_item(tick_item(16'd5000, 1'b0));      // right at the handshake timeout
        queue_item(cmd_item(4'd8, csm_pkg::CMD_HANDSHAKE));
        queue_item(cmd_item(4'd8, csm_pkg::CMD_READY));
        queue_item(tick_item(16'hFFFF, 1'b1));
        queue_item(req_item(4'd15, 16'd0, 16'd0));
        queue_item(req_item(4'd8, 16'd123, 16'd45));
        queue_item(cmd_item(4'd2, csm_pkg::CMD_START));
        queue_item(tick_item(16'd60000, 1'b1));
        queue_item(tick_item(16'd1, 1'b1));         // one past the charging timeout
        queue_item(tick_item(16'd7, 1'b0));
        queue_item(cmd_item(4'd1, csm_pkg::CMD_HANDSHAKE));
        queue_item(cmd_item(4'd1, csm_pkg::CMD_READY));
        queue_item(tick_item(16'd10, 1'b1));
        queue_item(cmd_item(4'd1, csm_pkg::CMD_STOP));
        queue_item(tick_item(16'd10, 1'b0));
        queue_item(cmd_item(4'd1, CMD_UNLISTED));
        queue_item(cmd_item(4'd9, 8'h00));
        queue_random(220, 1'b0);

        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 80, 0, 240);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 0, 80, 240);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 17, 17, 240);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(2000)),
                  16'($urandom_range(3000)), 0, 0, 120);
        drain();                                    // sender holds until all results are in
        queue_random(120, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 17, 17, 200);

        while (plan.state != csm_pkg::ST_FAULT)
            queue_random(1, 1'b1);
        queue_random(20, 1'b0);
        drain();

        if (expected_status.size() != 0)
        begin
            $error("%0d status results never arrived", expected_status.size());
            mismatches++;
        end
        $display("%0d requests over %0d register settings, %0d status results compared",
                 items_queued, settings, results_seen);
        $display("%0d charging sessions started; terminal fault entered from state %0d",
                 sessions, fault_from);
        if (mismatches == 0)
            $display("charger_session_state_machine: match");
        else
            $display("charger_session_state_machine: mismatch");
        $finish;
    end

endmodule

[sim.f]
rtl/csm_pkg.sv
rtl/csm_if.sv
rtl/csm_cfg_regs.sv
rtl/csm_in_stage.sv
rtl/csm_session.sv
rtl/charger_session_state_machine.sv
dv/charger_session_state_machine_tb.sv
